// ----- rtl/psa_pkg.sv -----
// psa_pkg: shared widths, codes and types of the pooled slot allocator
// no dependencies; used by the channel interfaces, the scan unit and the top level
`timescale 1ns / 1ps

package psa_pkg;

   // payload field widths
   localparam int FUNC_W   = 1;
   localparam int BIN_W    = 3;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 7;

   // bitmap word geometry
   localparam int WORD_BITS  = 8;
   localparam int WORD_IDX_W = 3;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

   // slots_per_bin after reset
   localparam logic [CSR_W-1:0] SPB_RESET = 7'd64;

   typedef struct packed {
      logic                  found;
      logic [WORD_IDX_W-1:0] idx;
   } scan_result_type;

endpackage

// ----- rtl/psa_channels.sv -----
// psa channel interfaces: request, response and register write channels
// depends on psa_pkg for field widths
`timescale 1ns / 1ps

interface psa_req_if;
   logic                        valid;
   logic                        ready;
   logic [psa_pkg::FUNC_W-1:0] func;
   logic [psa_pkg::BIN_W-1:0]  target_bin;
   logic [psa_pkg::SLOT_W-1:0] target_slot;

   modport source (output valid, func, target_bin, target_slot, input ready);
   modport sink   (input valid, func, target_bin, target_slot, output ready);
endinterface

interface psa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psa_pkg::STATUS_W-1:0] status;
   logic [psa_pkg::BIN_W-1:0]    out_bin;
   logic [psa_pkg::SLOT_W-1:0]   out_slot;

   modport source (output valid, status, out_bin, out_slot, input ready);
   modport sink   (input valid, status, out_bin, out_slot, output ready);
endinterface

interface psa_csr_if;
   logic                       valid;
   logic                       ready;
   logic [psa_pkg::CSR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/psa_ram.sv -----
// psa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/psa_scan.sv -----
// psa_scan: find-first-free over one bitmap word, limited to the bin size and hint
// depends on psa_pkg for the word geometry and the scan result type
`timescale 1ns / 1ps

module psa_scan #(
   parameter int SLW  = 6,
   parameter int NW   = 7,
   parameter int CMPW = 7
) (
   input  logic [psa_pkg::WORD_BITS-1:0]  word_data,
   input  logic [SLW-1:0]                 base,
   input  logic [NW-1:0]                  n_slots,
   input  logic [psa_pkg::WORD_IDX_W-1:0] lo_bit,
   output psa_pkg::scan_result_type       result
);

   logic [psa_pkg::WORD_BITS-1:0] avail;

   always_comb begin
      for (int i = 0; i < psa_pkg::WORD_BITS; i++) begin
         avail[i] = !word_data[i]
                    && (psa_pkg::WORD_IDX_W'(i) >= lo_bit)
                    && ((CMPW'(base) + CMPW'(i)) < CMPW'(n_slots));
      end
   end

   // lowest free bit wins
   always_comb begin
      result.found = 1'b0;
      result.idx   = '0;
      for (int i = psa_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            result.found = 1'b1;
            result.idx   = psa_pkg::WORD_IDX_W'(i);
         end
      end
   end

endmodule

// ----- rtl/pooled_slot_allocator_unit.sv -----
// pooled_slot_allocator_unit: top level, sequencer over the slot bitmap ram
// depends on psa_pkg, psa_channels, psa_ram and psa_scan
`timescale 1ns / 1ps

// channel   dir  payload                                   transfer
// req_chan  in   func, target_bin, target_slot             valid && ready
// rsp_chan  out  status, out_bin, out_slot                 valid && ready
// csr_chan  in   data = slots_per_bin                      valid && ready
//
// at most one 8-bit bitmap word read or written per cycle; one item at a time.
// free: read the word, then check and clear the bit, then respond; out of range skips the read.
// allocate: read and scan the words from the hint on, moving on to the next bin; a hint
//   past the bin size skips that bin; with no free slot a new bin is opened, its words cleared.
// after reset a clearing pass writes every word of bin 0; req is not ready until it ends.
// a held response stalls only the final output step; req is ready again in the cycle after it.

module pooled_slot_allocator_unit #(
   parameter int NUM_BINS  = 8,
   parameter int MAX_SLOTS = 64
) (
   input logic      clock,
   input logic      reset,
   psa_req_if.sink  req_chan,
   psa_rsp_if.source rsp_chan,
   psa_csr_if.sink  csr_chan
);

   localparam int WPB       = (MAX_SLOTS + psa_pkg::WORD_BITS - 1) / psa_pkg::WORD_BITS;
   localparam int WW        = (WPB > 1) ? $clog2(WPB) : 1;
   localparam int SLW       = WW + psa_pkg::WORD_IDX_W;
   localparam int BW        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int OW        = $clog2(NUM_BINS + 1);
   localparam int NW        = $clog2(MAX_SLOTS + 1);
   localparam int CMPW      = (SLW + 1 > 7) ? SLW + 1 : 7;
   localparam int BCW       = (OW > psa_pkg::BIN_W) ? OW : psa_pkg::BIN_W;
   localparam int RAM_DEPTH = NUM_BINS << WW;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam logic [WW-1:0] LAST_WORD = WW'(WPB - 1);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_FREE_RD   = 3'd2;
   localparam logic [2:0] S_FREE_CHK  = 3'd3;
   localparam logic [2:0] S_ALLOC_RD  = 3'd4;
   localparam logic [2:0] S_ALLOC_CHK = 3'd5;
   localparam logic [2:0] S_OPEN      = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   // control state
   logic [2:0]                 state_ff, state_in;
   logic [OW-1:0]              bins_open_ff, bins_open_in;
   logic [BW-1:0]              hint_bin_ff, hint_bin_in;
   logic [SLW-1:0]             hint_slot_ff, hint_slot_in;
   logic [psa_pkg::CSR_W-1:0]  spb_ff, spb_in;
   logic [BW-1:0]              clr_bin_ff, clr_bin_in;
   logic [WW-1:0]              clr_word_ff, clr_word_in;
   logic                       clr_mark_ff, clr_mark_in;
   logic                       clr_boot_ff, clr_boot_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload
   logic [psa_pkg::FUNC_W-1:0]   op_func_ff, op_func_in;
   logic [psa_pkg::BIN_W-1:0]    op_bin_ff, op_bin_in;
   logic [psa_pkg::SLOT_W-1:0]   op_slot_ff, op_slot_in;
   logic [OW-1:0]                cur_bin_ff, cur_bin_in;
   logic [WW-1:0]                cur_word_ff, cur_word_in;
   logic                         first_ff, first_in;
   logic [psa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [psa_pkg::BIN_W-1:0]    res_bin_ff, res_bin_in;
   logic [psa_pkg::SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [psa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [psa_pkg::BIN_W-1:0]    rsp_bin_ff, rsp_bin_in;
   logic [psa_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   // datapath
   logic [NW-1:0]                  n_slots;
   logic [BW-1:0]                  free_bin;
   logic [SLW-1:0]                 free_slot;
   logic                           free_bad;
   logic [SLW-1:0]                 cur_base;
   logic [SLW-1:0]                 alloc_slot;
   logic [RAM_AW-1:0]              free_addr, cur_addr, clr_addr;
   logic                           ram_we, ram_re;
   logic [RAM_AW-1:0]              ram_waddr, ram_raddr;
   logic [psa_pkg::WORD_BITS-1:0]  ram_wdata, ram_rdata;
   logic [psa_pkg::WORD_IDX_W-1:0] lo_bit;
   psa_pkg::scan_result_type       scan;
   logic                           req_fire, rsp_fire, out_free;

   // effective bin size: zero acts as one, clamp to MAX_SLOTS
   always_comb begin
      if (spb_ff == '0) begin
         n_slots = NW'(1);
      end else if (CMPW'(spb_ff) > CMPW'(MAX_SLOTS)) begin
         n_slots = NW'(MAX_SLOTS);
      end else begin
         n_slots = NW'(spb_ff);
      end
   end

   assign free_bin  = BW'(op_bin_ff);
   assign free_slot = SLW'(op_slot_ff);
   assign free_bad  = (BCW'(op_bin_ff) >= BCW'(bins_open_ff))
                      || (CMPW'(op_slot_ff) >= CMPW'(n_slots));
   assign cur_base  = {cur_word_ff, psa_pkg::WORD_IDX_W'(0)};
   assign alloc_slot = {cur_word_ff, scan.idx};
   assign free_addr = RAM_AW'({free_bin, free_slot[SLW-1:psa_pkg::WORD_IDX_W]});
   assign cur_addr  = RAM_AW'({cur_bin_ff[BW-1:0], cur_word_ff});
   assign clr_addr  = RAM_AW'({clr_bin_ff, clr_word_ff});
   assign lo_bit    = first_ff ? hint_slot_ff[psa_pkg::WORD_IDX_W-1:0] : '0;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.out_bin  = rsp_bin_ff;
   assign rsp_chan.out_slot = rsp_slot_ff;

   psa_ram #(
      .WIDTH (psa_pkg::WORD_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   psa_scan #(
      .SLW  (SLW),
      .NW   (NW),
      .CMPW (CMPW)
   ) u_scan (
      .word_data (ram_rdata),
      .base      (cur_base),
      .n_slots   (n_slots),
      .lo_bit    (lo_bit),
      .result    (scan)
   );

   always_comb begin
      state_in      = state_ff;
      bins_open_in  = bins_open_ff;
      hint_bin_in   = hint_bin_ff;
      hint_slot_in  = hint_slot_ff;
      spb_in        = spb_ff;
      clr_bin_in    = clr_bin_ff;
      clr_word_in   = clr_word_ff;
      clr_mark_in   = clr_mark_ff;
      clr_boot_in   = clr_boot_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_func_in    = op_func_ff;
      op_bin_in     = op_bin_ff;
      op_slot_in    = op_slot_ff;
      cur_bin_in    = cur_bin_ff;
      cur_word_in   = cur_word_ff;
      first_in      = first_ff;
      res_status_in = res_status_ff;
      res_bin_in    = res_bin_ff;
      res_slot_in   = res_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bin_in    = rsp_bin_ff;
      rsp_slot_in   = rsp_slot_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_addr;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = cur_addr;

      if (csr_chan.valid && csr_chan.ready) begin
         spb_in = csr_chan.data;
      end
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            // a newly opened bin gets its slot 0 taken in the same sweep
            ram_wdata = psa_pkg::WORD_BITS'(clr_mark_ff && clr_word_ff == '0);
            clr_word_in = clr_word_ff + WW'(1);
            if (clr_word_ff == LAST_WORD) begin
               if (clr_boot_ff) begin
                  state_in = S_IDLE;
               end else begin
                  hint_bin_in   = clr_bin_ff;
                  hint_slot_in  = '0;
                  res_status_in = psa_pkg::ST_OK;
                  res_bin_in    = psa_pkg::BIN_W'(clr_bin_ff);
                  res_slot_in   = '0;
                  state_in      = S_DONE;
               end
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_func_in  = req_chan.func;
               op_bin_in   = req_chan.target_bin;
               op_slot_in  = req_chan.target_slot;
               cur_bin_in  = OW'(hint_bin_ff);
               cur_word_in = hint_slot_ff[SLW-1:psa_pkg::WORD_IDX_W];
               first_in    = 1'b1;
               state_in    = (req_chan.func == psa_pkg::FUNC_FREE) ? S_FREE_RD : S_ALLOC_RD;
            end
         end
         S_FREE_RD: begin
            res_bin_in  = op_bin_ff;
            res_slot_in = op_slot_ff;
            if (free_bad) begin
               res_status_in = psa_pkg::ST_BAD;
               state_in      = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = free_addr;
               state_in  = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            if (!ram_rdata[op_slot_ff[psa_pkg::WORD_IDX_W-1:0]]) begin
               res_status_in = psa_pkg::ST_BAD;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = free_addr;
               ram_wdata = ram_rdata
                           & ~(psa_pkg::WORD_BITS'(1) << op_slot_ff[psa_pkg::WORD_IDX_W-1:0]);
               hint_bin_in   = free_bin;
               hint_slot_in  = free_slot;
               res_status_in = psa_pkg::ST_OK;
            end
            state_in = S_DONE;
         end
         S_ALLOC_RD: begin
            if (cur_bin_ff >= bins_open_ff) begin
               state_in = S_OPEN;
            end else if (CMPW'(cur_base) >= CMPW'(n_slots)) begin
               // hint lies past the bin size: nothing left in this bin
               cur_bin_in  = cur_bin_ff + OW'(1);
               cur_word_in = '0;
               first_in    = 1'b0;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = cur_addr;
               state_in  = S_ALLOC_CHK;
            end
         end
         S_ALLOC_CHK: begin
            if (scan.found) begin
               ram_we        = 1'b1;
               ram_waddr     = cur_addr;
               ram_wdata     = ram_rdata | (psa_pkg::WORD_BITS'(1) << scan.idx);
               hint_bin_in   = cur_bin_ff[BW-1:0];
               hint_slot_in  = alloc_slot;
               res_status_in = psa_pkg::ST_OK;
               res_bin_in    = psa_pkg::BIN_W'(cur_bin_ff[BW-1:0]);
               res_slot_in   = psa_pkg::SLOT_W'(alloc_slot);
               state_in      = S_DONE;
            end else begin
               first_in = 1'b0;
               state_in = S_ALLOC_RD;
               if (CMPW'(cur_base) + CMPW'(psa_pkg::WORD_BITS) >= CMPW'(n_slots)) begin
                  cur_bin_in  = cur_bin_ff + OW'(1);
                  cur_word_in = '0;
               end else begin
                  cur_word_in = cur_word_ff + WW'(1);
               end
            end
         end
         S_OPEN: begin
            if (bins_open_ff == OW'(NUM_BINS)) begin
               res_status_in = psa_pkg::ST_FULL;
               res_bin_in    = '0;
               res_slot_in   = '0;
               state_in      = S_DONE;
            end else begin
               clr_bin_in   = bins_open_ff[BW-1:0];
               clr_word_in  = '0;
               clr_mark_in  = 1'b1;
               clr_boot_in  = 1'b0;
               bins_open_in = bins_open_ff + OW'(1);
               state_in     = S_CLEAR;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bin_in    = res_bin_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         bins_open_ff <= OW'(1);
         hint_bin_ff  <= '0;
         hint_slot_ff <= '0;
         spb_ff       <= psa_pkg::SPB_RESET;
         clr_bin_ff   <= '0;
         clr_word_ff  <= '0;
         clr_mark_ff  <= 1'b0;
         clr_boot_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bins_open_ff <= bins_open_in;
         hint_bin_ff  <= hint_bin_in;
         hint_slot_ff <= hint_slot_in;
         spb_ff       <= spb_in;
         clr_bin_ff   <= clr_bin_in;
         clr_word_ff  <= clr_word_in;
         clr_mark_ff  <= clr_mark_in;
         clr_boot_ff  <= clr_boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_func_ff    <= op_func_in;
      op_bin_ff     <= op_bin_in;
      op_slot_ff    <= op_slot_in;
      cur_bin_ff    <= cur_bin_in;
      cur_word_ff   <= cur_word_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_bin_ff    <= res_bin_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // bins only open one at a time and never close outside reset
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && bins_open_ff != $past(bins_open_ff))
         |-> (bins_open_ff == $past(bins_open_ff) + OW'(1)))
      else $error("bins_open moved by other than one");

   assert property (@(posedge clock) disable iff (reset)
      (bins_open_ff != '0) && (bins_open_ff <= OW'(NUM_BINS)) && (OW'(hint_bin_ff) < bins_open_ff))
      else $error("open bin count or hint bin out of range");

   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_FREE_CHK || state_ff == S_ALLOC_CHK))
      else $error("bitmap write outside a write step");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the output step");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_FREE_RD || state_ff == S_ALLOC_RD))
      else $error("accepted request did not start a sequence");

endmodule
